@@ src/rgb2hsv_pkg.sv @@
// Shared types and sizes for the RGB to HSV converter.
package rgb2hsv_pkg;

  // channel width of the incoming pixel
  localparam int CHANNEL_BITS = 8;
  // hue and saturation are 16-bit fractions
  localparam int FRAC_BITS = 16;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } pixel_rgb_t;

  typedef struct packed {
    logic [FRAC_BITS-1:0]    hue;
    logic [FRAC_BITS-1:0]    saturation;
    logic [CHANNEL_BITS-1:0] value;
  } pixel_hsv_t;

endpackage

@@ src/rgb_to_hsv_converter.sv @@
// RGB to HSV converter: pipelined max/min stage, setup stage and two long dividers.
//
// Converts one RGB pixel per clock, while the output is not stalled, into hue,
// saturation and value. The word passes through a max/min stage, a divider
// setup stage, eight divider stages that each retire two quotient bits of both
// the hue and the saturation division, and an output register. Each stage holds
// its word only while the stage after it is full, so a stalled output fills the
// empty slots behind it before the input side stops taking words. Hue is a
// fraction of a full turn (65536 = one turn) and is 0 for gray; saturation is
// floor(range * 65535 / max) and is 0 for black; value is the largest channel.
// Ties for the largest channel go to red, then green.
module rgb_to_hsv_converter (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    pixel_valid,
  output logic                    pixel_ready,
  input  rgb2hsv_pkg::pixel_rgb_t pixel,
  output logic                    result_valid,
  input  logic                    result_ready,
  output rgb2hsv_pkg::pixel_hsv_t result
);
  import rgb2hsv_pkg::*;

  // two quotient bits per divider stage
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES = FRAC_BITS / STEPS_PER_STAGE;
  // 6 * range needs three more bits than a channel
  localparam int DEN_BITS = CHANNEL_BITS + 3;
  // partial remainder plus the bit shifted in
  localparam int REM_BITS = DEN_BITS + 1;
  localparam int PROD_BITS = CHANNEL_BITS + FRAC_BITS;

  // sector of the largest channel
  localparam logic [1:0] SECTOR_RED   = 2'd0;
  localparam logic [1:0] SECTOR_GREEN = 2'd1;
  localparam logic [1:0] SECTOR_BLUE  = 2'd2;

  typedef struct packed {
    logic [REM_BITS-1:0]     hue_rem;
    logic [DEN_BITS-1:0]     hue_den;
    logic [FRAC_BITS-1:0]    hue_quo;
    logic [REM_BITS-1:0]     sat_rem;
    logic [CHANNEL_BITS-1:0] sat_den;
    logic [FRAC_BITS-1:0]    sat_num;
    logic [FRAC_BITS-1:0]    sat_quo;
    logic                    gray;
    logic                    black;
    logic [CHANNEL_BITS-1:0] value;
  } div_word_t;

  // one restoring step of both dividers
  function automatic div_word_t div_step(div_word_t w);
    div_word_t           o;
    logic [REM_BITS-1:0] hs;
    logic [REM_BITS-1:0] ss;
    logic [REM_BITS-1:0] hd;
    logic [REM_BITS-1:0] sd;
    o  = w;
    hd = REM_BITS'(w.hue_den);
    sd = REM_BITS'(w.sat_den);
    hs = {w.hue_rem[REM_BITS-2:0], 1'b0};
    ss = {w.sat_rem[REM_BITS-2:0], w.sat_num[FRAC_BITS-1]};
    if (hs >= hd) begin
      o.hue_rem = hs - hd;
      o.hue_quo = {w.hue_quo[FRAC_BITS-2:0], 1'b1};
    end else begin
      o.hue_rem = hs;
      o.hue_quo = {w.hue_quo[FRAC_BITS-2:0], 1'b0};
    end
    if (ss >= sd) begin
      o.sat_rem = ss - sd;
      o.sat_quo = {w.sat_quo[FRAC_BITS-2:0], 1'b1};
    end else begin
      o.sat_rem = ss;
      o.sat_quo = {w.sat_quo[FRAC_BITS-2:0], 1'b0};
    end
    o.sat_num = {w.sat_num[FRAC_BITS-2:0], 1'b0};
    return o;
  endfunction

  // stage A: max, span (max minus min), sector and the two channels of the hue difference
  logic                    a_valid;
  logic [CHANNEL_BITS-1:0] a_max;
  logic [CHANNEL_BITS-1:0] a_span;
  logic [1:0]              a_sector;
  logic [CHANNEL_BITS-1:0] a_plus;
  logic [CHANNEL_BITS-1:0] a_minus;

  // stage B: divider operands
  logic      b_valid;
  div_word_t b_word;

  // divider stages
  logic      d_valid [DIV_STAGES];
  div_word_t d_word  [DIV_STAGES];

  // per-stage "will be free after this edge"
  logic take_a;
  logic take_b;
  logic take_d [DIV_STAGES+1];

  // combinational values for stages A and B
  logic [CHANNEL_BITS-1:0] max_next;
  logic [CHANNEL_BITS-1:0] min_next;
  logic [1:0]              sector_next;
  logic [CHANNEL_BITS-1:0] plus_next;
  logic [CHANNEL_BITS-1:0] minus_next;
  logic [REM_BITS-1:0]     off_span;
  logic [REM_BITS-1:0]     hue_num;
  logic [DEN_BITS-1:0]     den6;
  logic [PROD_BITS-1:0]    sat_prod;
  div_word_t               b_next;

  // ready chain from the output back to the input
  assign take_d[DIV_STAGES] = ~result_valid | result_ready;
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_take
    assign take_d[k] = ~d_valid[k] | take_d[k+1];
  end
  assign take_b      = ~b_valid | take_d[0];
  assign take_a      = ~a_valid | take_b;
  assign pixel_ready = take_a;

  // largest channel with red then green winning ties
  always_comb begin
    if (pixel.red >= pixel.green && pixel.red >= pixel.blue) begin
      max_next    = pixel.red;
      sector_next = SECTOR_RED;
      plus_next   = pixel.green;
      minus_next  = pixel.blue;
    end else if (pixel.green >= pixel.blue) begin
      max_next    = pixel.green;
      sector_next = SECTOR_GREEN;
      plus_next   = pixel.blue;
      minus_next  = pixel.red;
    end else begin
      max_next    = pixel.blue;
      sector_next = SECTOR_BLUE;
      plus_next   = pixel.red;
      minus_next  = pixel.green;
    end
    if (pixel.red <= pixel.green && pixel.red <= pixel.blue) begin
      min_next = pixel.red;
    end else if (pixel.green <= pixel.blue) begin
      min_next = pixel.green;
    end else begin
      min_next = pixel.blue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (take_a) begin
      a_valid <= pixel_valid;
    end
    if (take_a) begin
      a_max    <= max_next;
      a_span   <= max_next - min_next;
      a_sector <= sector_next;
      a_plus   <= plus_next;
      a_minus  <= minus_next;
    end
  end

  // hue numerator folded into [0, 6*range), denominators, range * 65535
  always_comb begin
    case (a_sector)
      SECTOR_GREEN: off_span = REM_BITS'({a_span, 1'b0});
      SECTOR_BLUE:  off_span = REM_BITS'({a_span, 2'b00});
      default:      off_span = '0;
    endcase
    den6    = DEN_BITS'({a_span, 2'b00}) + DEN_BITS'({a_span, 1'b0});
    hue_num = REM_BITS'(a_plus) + off_span - REM_BITS'(a_minus);
    // negative hue wraps by one full turn
    if (hue_num[REM_BITS-1]) begin
      hue_num = hue_num + REM_BITS'(den6);
    end
    sat_prod = {a_span, FRAC_BITS'(0)} - PROD_BITS'(a_span);

    b_next         = '0;
    b_next.hue_rem = hue_num;
    b_next.hue_den = den6;
    b_next.sat_rem = REM_BITS'(sat_prod[PROD_BITS-1:FRAC_BITS]);
    b_next.sat_den = a_max;
    b_next.sat_num = sat_prod[FRAC_BITS-1:0];
    b_next.gray    = (a_span == '0);
    b_next.black   = (a_max == '0);
    b_next.value   = a_max;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (take_b) begin
      b_valid <= a_valid;
    end
    if (take_b) begin
      b_word <= b_next;
    end
  end

  // divider stages, two quotient bits each
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic      prev_valid;
    div_word_t prev_word;
    div_word_t step_word [STEPS_PER_STAGE+1];

    if (k == 0) begin : g_first
      assign prev_valid = b_valid;
      assign prev_word  = b_word;
    end else begin : g_rest
      assign prev_valid = d_valid[k-1];
      assign prev_word  = d_word[k-1];
    end

    assign step_word[0] = prev_word;
    for (genvar s = 0; s < STEPS_PER_STAGE; s++) begin : g_step
      assign step_word[s+1] = div_step(step_word[s]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d_valid[k] <= 1'b0;
      end else if (take_d[k]) begin
        d_valid[k] <= prev_valid;
      end
      if (take_d[k]) begin
        d_word[k] <= step_word[STEPS_PER_STAGE];
      end
    end
  end

  // output register with gray and black overrides
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take_d[DIV_STAGES]) begin
      result_valid <= d_valid[DIV_STAGES-1];
    end
    if (take_d[DIV_STAGES]) begin
      result.hue        <= d_word[DIV_STAGES-1].gray ? '0 : d_word[DIV_STAGES-1].hue_quo;
      result.saturation <= d_word[DIV_STAGES-1].black ? '0 : d_word[DIV_STAGES-1].sat_quo;
      result.value      <= d_word[DIV_STAGES-1].value;
    end
  end

endmodule

@@ bench/hsv_checker.sv @@
// Watches both channels of the RGB to HSV converter, predicts each word and compares.
`timescale 1ns / 100ps

module hsv_checker (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    pixel_valid,
  input  logic                    pixel_ready,
  input  rgb2hsv_pkg::pixel_rgb_t pixel,
  input  logic                    result_valid,
  input  logic                    result_ready,
  input  rgb2hsv_pkg::pixel_hsv_t result,
  output int                      mismatches,
  output int                      pending
);
  import rgb2hsv_pkg::*;

  // HSV words still owed by the converter, oldest first
  pixel_hsv_t expected_hsv[$];

  // Exact fixed-point conversion of one pixel
  function automatic pixel_hsv_t convert_pixel(input pixel_rgb_t px);
    logic [CHANNEL_BITS-1:0] hi;
    logic [CHANNEL_BITS-1:0] lo;
    logic [63:0]             span;
    logic [63:0]             plus;
    logic [63:0]             minus;
    logic [63:0]             offset;
    logic [63:0]             numer;
    logic [63:0]             quot;
    pixel_hsv_t              res;
    hi = px.red;
    if (px.green > hi) hi = px.green;
    if (px.blue > hi) hi = px.blue;
    lo = px.red;
    if (px.green < lo) lo = px.green;
    if (px.blue < lo) lo = px.blue;
    span = 64'(hi) - 64'(lo);
    res.value = hi;
    res.saturation = (hi == 0) ? '0 : FRAC_BITS'((span * 64'd65535) / 64'(hi));
    if (span == 0) begin
      res.hue = '0;
    end else begin
      // red wins ties, then green
      if (hi == px.red) begin
        plus = 64'(px.green); minus = 64'(px.blue); offset = 64'd0;
      end else if (hi == px.green) begin
        plus = 64'(px.blue); minus = 64'(px.red); offset = 64'd2;
      end else begin
        plus = 64'(px.red); minus = 64'(px.green); offset = 64'd4;
      end
      // one extra full turn keeps the numerator positive; the wrap drops it
      numer = (plus + (offset + 64'd6) * span - minus) << 16;
      quot = numer / (64'd6 * span);
      res.hue = quot[FRAC_BITS-1:0];
    end
    return res;
  endfunction

  initial begin
    mismatches = 0;
    pending = 0;
  end

  // Compare results first, then record newly accepted pixels
  always @(posedge clk) begin
    pixel_hsv_t want;
    int         errs;
    errs = 0;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (expected_hsv.size() == 0) begin
          $display("%0t: unexpected word: hue %h sat %h value %h", $time,
                   result.hue, result.saturation, result.value);
          errs++;
        end else begin
          want = expected_hsv.pop_front();
          if (result.hue !== want.hue) begin
            $display("%0t: hue mismatch: expected %h, got %h", $time, want.hue, result.hue);
            errs++;
          end
          if (result.saturation !== want.saturation) begin
            $display("%0t: saturation mismatch: expected %h, got %h", $time,
                     want.saturation, result.saturation);
            errs++;
          end
          if (result.value !== want.value) begin
            $display("%0t: value mismatch: expected %h, got %h", $time,
                     want.value, result.value);
            errs++;
          end
        end
      end
      if (pixel_valid && pixel_ready) expected_hsv.push_back(convert_pixel(pixel));
    end
    mismatches <= mismatches + errs;
    pending <= expected_hsv.size();
  end

endmodule

@@ bench/testbench.sv @@
// Top of the RGB to HSV converter bench: clock, reset, pixel stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
  import rgb2hsv_pkg::*;

  logic       clk;
  logic       rst;
  logic       pixel_valid;
  logic       pixel_ready;
  pixel_rgb_t pixel;
  logic       result_valid;
  logic       result_ready;
  pixel_hsv_t result;
  int         mismatches;
  int         pending;

  // idle rates in percent, and long output stall requests
  int send_idle_pct;
  int recv_idle_pct;
  int hold_reqs;
  int hold_seen = 0;
  int hold_left = 0;

  // what went through
  int sent_count = 0;
  int gray_count = 0;
  int tie_count = 0;

  rgb_to_hsv_converter u_top (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  hsv_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Output side: random stalls, plus a long hold-off whenever one is requested
  initial result_ready = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_ready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= 200;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offer one pixel, with random idle cycles first, and wait for acceptance
  task automatic send_pixel(input pixel_rgb_t px);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= px;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    sent_count++;
    if (px.red == px.green && px.green == px.blue) gray_count++;
    else if ((px.red == px.green && px.red >= px.blue) ||
             (px.red == px.blue && px.red >= px.green) ||
             (px.green == px.blue && px.green >= px.red)) tie_count++;
  endtask

  // Stop offering and wait until every owed word has come back
  task automatic wait_drained();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random pixels, biased toward grays, ties, extremes and near-grays
  task automatic run_phase(input int count, input int send_pct, input int recv_pct,
                           input bit long_hold);
    int         r;
    int         g;
    int         b;
    pixel_rgb_t px;
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 255);
      g = $urandom_range(0, 255);
      b = $urandom_range(0, 255);
      case ($urandom_range(0, 9))
        5: begin
          g = r;
          b = r;
        end
        6: begin
          case ($urandom_range(0, 2))
            0: begin g = r; b = $urandom_range(0, r); end
            1: begin b = r; g = $urandom_range(0, r); end
            default: begin b = g; r = $urandom_range(0, g); end
          endcase
        end
        7: begin
          if ($urandom_range(0, 1)) r = $urandom_range(0, 1) * 255;
          if ($urandom_range(0, 1)) g = $urandom_range(0, 1) * 255;
          if ($urandom_range(0, 1)) b = $urandom_range(0, 1) * 255;
        end
        8: begin
          r = $urandom_range(0, 3);
          g = $urandom_range(0, 3);
          b = $urandom_range(0, 3);
        end
        9: begin
          g = (r + $urandom_range(0, 3)) & 255;
          b = (r - $urandom_range(0, 3)) & 255;
        end
        default: ;
      endcase
      px.red = 8'(r);
      px.green = 8'(g);
      px.blue = 8'(b);
      // stall the output long enough to fill the pipe and block the input
      if (long_hold && i == 100) hold_reqs <= hold_reqs + 1;
      send_pixel(px);
    end
    wait_drained();
  endtask

  // Stimulus and verdict
  initial begin
    logic [23:0] corners [18] = '{
      24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000, 24'h00FF00,
      24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'hFF00FE,
      24'h010000, 24'h000001, 24'hFEFF00, 24'h0001FF, 24'h7F00FF, 24'h01FF00
    };
    rst = 1'b1;
    pixel_valid = 1'b0;
    pixel = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_reqs = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners: black, white, grays, primaries, ties, hue wrap
    recv_idle_pct <= 30;
    foreach (corners[i]) send_pixel(pixel_rgb_t'(corners[i]));
    wait_drained();

    run_phase(560, 18, 81, 1'b0);
    run_phase(560, 81, 18, 1'b0);
    run_phase(560, 0, 0, 1'b1);

    repeat (30) @(posedge clk);
    $display("Converted %0d pixels (%0d gray, %0d with a tied maximum)", sent_count,
             gray_count, tie_count);
    $display("Idle profiles: light/heavy, heavy/light, none, with one long output stall");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timeout with %0d words outstanding", pending);
    $display("Test completed with failures");
    $finish;
  end

endmodule
